// ===== rtl/fraction_arithmetic_unit_assert.svh =====
// ----------------------------------------------------------------------------
// fraction_arithmetic_unit assertion macros
// Shared concurrent assertion forms for the fraction arithmetic unit.
// ----------------------------------------------------------------------------
`ifndef FRACTION_ARITHMETIC_UNIT_ASSERT_SVH
`define FRACTION_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define FAU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fraction_arithmetic_unit: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define FAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fraction_arithmetic_unit: next-cycle check failed");

`endif

// ===== rtl/fau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fau_pkg
// Types and codes shared by the fraction arithmetic unit controller and datapath.
// ----------------------------------------------------------------------------
package fau_pkg;

	// Action codes of an input transaction
	localparam logic [1:0] ACT_REDUCE = 2'd0;
	localparam logic [1:0] ACT_ADD    = 2'd1;
	localparam logic [1:0] ACT_MUL    = 2'd2;
	localparam logic [1:0] ACT_DIV    = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MUL2,
		ST_MUL3,
		ST_DEN,
		ST_GCD_INIT,
		ST_GCD_TEST,
		ST_GCD_DIV,
		ST_NUM_DIV,
		ST_DEN_DIV,
		ST_FINISH
	} state_t;

	// Operand pair for the shared multiplier
	typedef enum logic [1:0] {
		MUL_NA_DB,
		MUL_DA_NB,
		MUL_NA_NB,
		MUL_DA_DB
	} mul_sel_t;

	typedef enum logic [1:0] {
		N_HOLD,
		N_RAW,
		N_PROD,
		N_ADD
	} n_op_t;

	typedef enum logic [1:0] {
		D_HOLD,
		D_RAW,
		D_PROD
	} d_op_t;

	// Operand source for the shared divider
	typedef enum logic [1:0] {
		DIV_EUCLID,
		DIV_NUM,
		DIV_DEN
	} div_src_t;

	typedef struct packed {
		logic     load_in;
		logic     mul_en;
		mul_sel_t mul_sel;
		n_op_t    n_op;
		d_op_t    d_op;
		logic     gcd_init;
		logic     gcd_step;
		logic     div_start;
		div_src_t div_src;
		logic     num_ld;
		logic     den_ld;
		logic     zero_res;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       x_zero;
		logic       y_zero;
		logic       div_done;
	} sts_t;

endpackage

// ===== rtl/fau_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fau_div
// Radix-2 restoring divider with C truncating semantics: quotient rounds
// toward zero, remainder takes the sign of the dividend. One bit per cycle.
// ----------------------------------------------------------------------------
module fau_div #(
	parameter int WIDTH = 33
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [WIDTH-1:0] dividend,
	input  logic signed [WIDTH-1:0] divisor,
	output logic                    done,
	output logic signed [WIDTH-1:0] quotient,
	output logic signed [WIDTH-1:0] remainder
);

	localparam int CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] dvd_mag;
	logic [WIDTH-1:0] dvs_mag;
	logic [WIDTH-1:0] dvs_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic             qneg_q;
	logic             rneg_q;
	logic [CW-1:0]    cnt_q;
	logic [WIDTH:0]   r_sh;
	logic [WIDTH:0]   diff;
	logic             ge;

	// Take magnitudes of the operands
	assign dvd_mag = dividend[WIDTH-1] ? (~dividend + 1'b1) : dividend;
	assign dvs_mag = divisor[WIDTH-1] ? (~divisor + 1'b1) : divisor;

	// Trial subtract of the shifted partial remainder
	assign r_sh = {rem_q, quo_q[WIDTH-1]};
	assign ge   = (r_sh >= {1'b0, dvs_q});
	assign diff = r_sh - {1'b0, dvs_q};

	// Count down the quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(WIDTH);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Load operands, then shift one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q  <= dvs_mag;
			rem_q  <= '0;
			quo_q  <= dvd_mag;
			qneg_q <= dividend[WIDTH-1] ^ divisor[WIDTH-1];
			rneg_q <= dividend[WIDTH-1];
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[WIDTH-1:0] : r_sh[WIDTH-1:0];
			quo_q <= {quo_q[WIDTH-2:0], ge};
		end
	end

	// Restore signs
	assign done      = (cnt_q == '0);
	assign quotient  = qneg_q ? (~quo_q + 1'b1) : quo_q;
	assign remainder = rneg_q ? (~rem_q + 1'b1) : rem_q;

endmodule

// ===== rtl/fau_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fau_datapath
// Operand registers, shared multiplier, raw fraction, Euclid registers, shared
// divider and output register of the fraction arithmetic unit.
// ----------------------------------------------------------------------------
module fau_datapath #(
	parameter int OW = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fau_pkg::cmd_t          cmd,
	output fau_pkg::sts_t          sts,
	input  logic [1:0]             action,
	input  logic signed [OW-1:0]   num_a,
	input  logic signed [OW-1:0]   den_a,
	input  logic signed [OW-1:0]   num_b,
	input  logic signed [OW-1:0]   den_b,
	output logic signed [2*OW:0]   result_num,
	output logic signed [2*OW-1:0] result_den,
	output logic                   zero_den
);

	localparam int PW = 2 * OW;
	localparam int NW = 2 * OW + 1;

	logic [1:0]           act_q;
	logic signed [OW-1:0] na_q;
	logic signed [OW-1:0] da_q;
	logic signed [OW-1:0] nb_q;
	logic signed [OW-1:0] db_q;
	logic signed [OW-1:0] ma;
	logic signed [OW-1:0] mb;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] prod_q;
	logic signed [NW-1:0] prod_ext;
	logic signed [NW-1:0] n_q;
	logic signed [NW-1:0] d_q;
	logic signed [NW-1:0] x_q;
	logic signed [NW-1:0] y_q;
	logic signed [NW-1:0] rn_q;
	logic signed [NW-1:0] rd_q;
	logic signed [NW-1:0] div_dvd;
	logic signed [NW-1:0] div_dvs;
	logic signed [NW-1:0] div_quo;
	logic signed [NW-1:0] div_rem;
	logic                 div_done;
	logic signed [NW-1:0] result_num_q;
	logic signed [PW-1:0] result_den_q;
	logic                 zero_den_q;

	// Capture the input transaction
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			act_q <= action;
			na_q  <= num_a;
			da_q  <= den_a;
			nb_q  <= num_b;
			db_q  <= den_b;
		end
	end

	// Select multiplier operands
	always_comb begin
		case (cmd.mul_sel)
			fau_pkg::MUL_NA_DB: begin ma = na_q; mb = db_q; end
			fau_pkg::MUL_DA_NB: begin ma = da_q; mb = nb_q; end
			fau_pkg::MUL_NA_NB: begin ma = na_q; mb = nb_q; end
			fau_pkg::MUL_DA_DB: begin ma = da_q; mb = db_q; end
			default:            begin ma = na_q; mb = db_q; end
		endcase
	end

	assign prod     = ma * mb;
	assign prod_ext = {{(NW-PW){prod_q[PW-1]}}, prod_q};

	// Register the product
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= prod;
		end
	end

	// Build the raw numerator and denominator
	always_ff @(posedge clk) begin
		case (cmd.n_op)
			fau_pkg::N_RAW:  n_q <= {{(NW-OW){na_q[OW-1]}}, na_q};
			fau_pkg::N_PROD: n_q <= prod_ext;
			fau_pkg::N_ADD:  n_q <= n_q + prod_ext;
			default:         n_q <= n_q;
		endcase
		case (cmd.d_op)
			fau_pkg::D_RAW:  d_q <= {{(NW-OW){da_q[OW-1]}}, da_q};
			fau_pkg::D_PROD: d_q <= prod_ext;
			default:         d_q <= d_q;
		endcase
	end

	// Advance the Euclid pair
	always_ff @(posedge clk) begin
		if (cmd.gcd_init) begin
			x_q <= n_q;
			y_q <= d_q;
		end else if (cmd.gcd_step) begin
			x_q <= y_q;
			y_q <= div_rem;
		end
	end

	// Select divider operands; x holds the gcd once y is zero
	always_comb begin
		case (cmd.div_src)
			fau_pkg::DIV_EUCLID: begin div_dvd = x_q; div_dvs = y_q; end
			fau_pkg::DIV_NUM:    begin div_dvd = n_q; div_dvs = x_q; end
			fau_pkg::DIV_DEN:    begin div_dvd = d_q; div_dvs = x_q; end
			default:             begin div_dvd = x_q; div_dvs = y_q; end
		endcase
	end

	fau_div #(
		.WIDTH (NW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Hold the reduced fraction
	always_ff @(posedge clk) begin
		if (cmd.zero_res) begin
			rn_q <= '0;
			rd_q <= '0;
		end else begin
			if (cmd.num_ld) begin
				rn_q <= div_quo;
			end
			if (cmd.den_ld) begin
				rd_q <= div_quo;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_num_q <= rn_q;
			result_den_q <= rd_q[PW-1:0];
			zero_den_q   <= (rd_q == '0);
		end
	end

	assign result_num = result_num_q;
	assign result_den = result_den_q;
	assign zero_den   = zero_den_q;

	assign sts.action   = act_q;
	assign sts.x_zero   = (x_q == '0);
	assign sts.y_zero   = (y_q == '0);
	assign sts.div_done = div_done;

endmodule

// ===== rtl/fau_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fau_ctrl
// Sequencer of the fraction arithmetic unit: products, Euclid loop, final
// exact divisions and the output handshake.
// ----------------------------------------------------------------------------
`include "fraction_arithmetic_unit_assert.svh"

module fau_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  fau_pkg::sts_t  sts,
	output fau_pkg::cmd_t  cmd
);

	fau_pkg::state_t state_q;
	fau_pkg::state_t state_d;
	logic            out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fau_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the result valid until the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == fau_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			fau_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = fau_pkg::ST_DECODE;
				end
			end
			fau_pkg::ST_DECODE: begin
				if (sts.action == fau_pkg::ACT_REDUCE) begin
					cmd.n_op = fau_pkg::N_RAW;
					cmd.d_op = fau_pkg::D_RAW;
					state_d  = fau_pkg::ST_GCD_INIT;
				end else begin
					cmd.mul_en  = 1'b1;
					cmd.mul_sel = (sts.action == fau_pkg::ACT_MUL) ?
						fau_pkg::MUL_NA_NB : fau_pkg::MUL_NA_DB;
					state_d     = fau_pkg::ST_MUL2;
				end
			end
			fau_pkg::ST_MUL2: begin
				cmd.n_op    = fau_pkg::N_PROD;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = (sts.action == fau_pkg::ACT_MUL) ?
					fau_pkg::MUL_DA_DB : fau_pkg::MUL_DA_NB;
				state_d     = (sts.action == fau_pkg::ACT_ADD) ?
					fau_pkg::ST_MUL3 : fau_pkg::ST_DEN;
			end
			fau_pkg::ST_MUL3: begin
				cmd.n_op    = fau_pkg::N_ADD;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = fau_pkg::MUL_DA_DB;
				state_d     = fau_pkg::ST_DEN;
			end
			fau_pkg::ST_DEN: begin
				cmd.d_op = fau_pkg::D_PROD;
				state_d  = fau_pkg::ST_GCD_INIT;
			end
			fau_pkg::ST_GCD_INIT: begin
				cmd.gcd_init = 1'b1;
				state_d      = fau_pkg::ST_GCD_TEST;
			end
			fau_pkg::ST_GCD_TEST: begin
				if (!sts.y_zero) begin
					cmd.div_start = 1'b1;
					cmd.div_src   = fau_pkg::DIV_EUCLID;
					state_d       = fau_pkg::ST_GCD_DIV;
				end else if (sts.x_zero) begin
					// zero over zero: no gcd, result is 0/0
					cmd.zero_res = 1'b1;
					state_d      = fau_pkg::ST_FINISH;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_src   = fau_pkg::DIV_NUM;
					state_d       = fau_pkg::ST_NUM_DIV;
				end
			end
			fau_pkg::ST_GCD_DIV: begin
				cmd.div_src = fau_pkg::DIV_EUCLID;
				if (sts.div_done) begin
					cmd.gcd_step = 1'b1;
					state_d      = fau_pkg::ST_GCD_TEST;
				end
			end
			fau_pkg::ST_NUM_DIV: begin
				cmd.div_src = fau_pkg::DIV_NUM;
				if (sts.div_done) begin
					cmd.num_ld    = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_src   = fau_pkg::DIV_DEN;
					state_d       = fau_pkg::ST_DEN_DIV;
				end
			end
			fau_pkg::ST_DEN_DIV: begin
				cmd.div_src = fau_pkg::DIV_DEN;
				if (sts.div_done) begin
					cmd.den_ld = 1'b1;
					state_d    = fau_pkg::ST_FINISH;
				end
			end
			fau_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = fau_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fau_pkg::ST_IDLE;
			end
		endcase
	end

	// An accepted transaction always starts decoding
	`FAU_ASSERT_NEXT(a_accept_decode, clk, arst_n, in_valid && in_ready, state_q == fau_pkg::ST_DECODE)
	// Never overwrite a result that is still waiting
	`FAU_ASSERT_IMPL(a_no_overwrite, clk, arst_n, cmd.out_load, !out_valid_q || out_ready)
	// Divider is busy right after a start
	`FAU_ASSERT_NEXT(a_div_busy, clk, arst_n, cmd.div_start, !sts.div_done)

endmodule

// ===== rtl/fraction_arithmetic_unit.sv =====
// Sequence: form the raw fraction and load the Euclid pair, then one divider run
// per Euclid remainder step, a final zero test and the two final divisions (none
// for zero over zero), then the output load. The divider is NW = 2*OPERAND_WIDTH + 1
// bits wide (33 for 16-bit operands).
// Throughput: one transaction at a time; the next is taken the cycle after the result loads.
// Reset: arst_n clears the sequencer, the divider count and the output valid.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_arithmetic_unit
// Reduces, adds, multiplies or divides two signed fractions and reduces the
// result by its Euclid gcd with truncating remainders.
// ----------------------------------------------------------------------------
module fraction_arithmetic_unit #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        action,
	input  logic signed [OPERAND_WIDTH-1:0]   num_a,
	input  logic signed [OPERAND_WIDTH-1:0]   den_a,
	input  logic signed [OPERAND_WIDTH-1:0]   num_b,
	input  logic signed [OPERAND_WIDTH-1:0]   den_b,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [2*OPERAND_WIDTH:0]   result_num,
	output logic signed [2*OPERAND_WIDTH-1:0] result_den,
	output logic                              zero_den
);

	fau_pkg::cmd_t cmd;
	fau_pkg::sts_t sts;

	// Sequencer
	fau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Arithmetic
	fau_datapath #(
		.OW (OPERAND_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.action     (action),
		.num_a      (num_a),
		.den_a      (den_a),
		.num_b      (num_b),
		.den_b      (den_b),
		.result_num (result_num),
		.result_den (result_den),
		.zero_den   (zero_den)
	);

endmodule
